// ===== rtl/aabb_pkg.sv =====
`default_nettype none

package aabb_pkg;

    localparam int CMD_W  = 3;
    localparam int POS_W  = 20;
    localparam int SIZE_W = 12;
    localparam int KIND_W = 3;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_DEL_KIND = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_QUERY    = 3'd4
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_HIT  = 2'd2,
        ST_MISS = 2'd3
    } rsp_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic [KIND_W-1:0]       kind;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    typedef struct packed {
        logic idle;
        logic do_exec;
        logic sweep_step;
        logic load_out;
    } ctl_t;

    typedef struct packed {
        logic accepted;
        cmd_t in_cmd;
        logic sweep_done;
        logic out_free;
    } st_t;

endpackage

`default_nettype wire

// ===== rtl/aabb_if.sv =====
`default_nettype none

interface aabb_req_if;
    logic                                valid;
    logic                                ready;
    logic [aabb_pkg::CMD_W-1:0]          cmd;
    logic signed [aabb_pkg::POS_W-1:0]   pos_x;
    logic signed [aabb_pkg::POS_W-1:0]   pos_y;
    logic [aabb_pkg::SIZE_W-1:0]         width;
    logic [aabb_pkg::SIZE_W-1:0]         height;
    logic [aabb_pkg::KIND_W-1:0]         kind;
    logic [aabb_pkg::TAG_W-1:0]          handle;

    modport source (output valid, cmd, pos_x, pos_y, width, height, kind, handle,
                    input ready);
    modport sink (input valid, cmd, pos_x, pos_y, width, height, kind, handle,
                  output ready);
endinterface

interface aabb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [aabb_pkg::STAT_W-1:0]   status;
    logic [aabb_pkg::TAG_W-1:0]    found_tag;
    logic [aabb_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, status, found_tag, occupancy, input ready);
    modport sink (input valid, status, found_tag, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/aabb_class_collision_table.sv =====
// Insert, clear and unused commands pass an execute state; delete, delete-class
// and query scan the table through one memory read port, one slot a cycle (a
// query stops at its hit). Each then waits in a response state until the output
// register is free. Commands are taken one at a time; the next command is accepted
// once the previous result is in the output register.
// Reset: asynchronous, active low; empties the table and zeroes the tag counter.
`default_nettype none

module aabb_class_collision_table #(
    parameter int CAPACITY  = 64,
    parameter int FRAC_BITS = 4
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    aabb_req_if.sink     req,
    aabb_rsp_if.source   rsp
);
    import aabb_pkg::*;

    ctl_t ctl;
    st_t  st;

    aabb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    aabb_dp #(
        .CAPACITY  (CAPACITY),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .st    (st)
    );

endmodule

`default_nettype wire

// ===== rtl/aabb_ctrl.sv =====
`default_nettype none

module aabb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire aabb_pkg::st_t  st,
    output aabb_pkg::ctl_t      ctl
);
    import aabb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.idle = 1'b1;
                if (st.accepted)
                begin
                    if (st.in_cmd inside {CMD_DELETE, CMD_DEL_KIND, CMD_QUERY})
                    begin
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                ctl.do_exec = 1'b1;
                state_next  = S_RESP;
            end
            S_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                if (st.sweep_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                ctl.load_out = st.out_free;
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/aabb_dp.sv =====
`default_nettype none

module aabb_dp #(
    parameter int CAPACITY  = 64,
    parameter int FRAC_BITS = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    aabb_req_if.sink            req,
    aabb_rsp_if.source          rsp,
    input  wire aabb_pkg::ctl_t ctl,
    output aabb_pkg::st_t       st
);
    import aabb_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int SUM_W = (((FRAC_BITS + 13) > POS_W) ? (FRAC_BITS + 13) : POS_W) + 1;

    entry_t slot_mem [CAPACITY];
    entry_t rd_data_reg;

    entry_t      q_reg, q_next;
    logic [TAG_W-1:0] handle_reg, handle_next;
    cmd_t        cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TAG_W-1:0] next_tag_reg, next_tag_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] wr_idx_reg, wr_idx_next;
    logic        pend_reg, pend_next;
    rsp_status_t res_status_reg, res_status_next;
    logic [TAG_W-1:0] res_tag_reg, res_tag_next;
    logic        out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic [OCC_W-1:0]  out_occ_reg, out_occ_next;

    logic          we;
    logic [AW-1:0] wa;
    entry_t        wd;

    logic accept;
    logic more;
    logic is_query;
    logic drop;
    logic hit;
    logic overlap;
    logic full;

    logic signed [SUM_W-1:0] a_x, a_y, a_w, a_h;
    logic signed [SUM_W-1:0] b_x, b_y, b_w, b_h;

    assign req.ready = ctl.idle;
    assign accept    = req.valid && ctl.idle;

    assign a_x = SUM_W'($signed(q_reg.x));
    assign a_y = SUM_W'($signed(q_reg.y));
    assign a_w = SUM_W'(q_reg.w) << FRAC_BITS;
    assign a_h = SUM_W'(q_reg.h) << FRAC_BITS;
    assign b_x = SUM_W'($signed(rd_data_reg.x));
    assign b_y = SUM_W'($signed(rd_data_reg.y));
    assign b_w = SUM_W'(rd_data_reg.w) << FRAC_BITS;
    assign b_h = SUM_W'(rd_data_reg.h) << FRAC_BITS;

    assign overlap = (a_x < b_x + b_w) && (b_x < a_x + a_w) &&
                     (a_y < b_y + b_h) && (b_y < a_y + a_h);

    assign more     = rd_idx_reg < count_reg;
    assign is_query = cmd_reg == CMD_QUERY;
    assign full     = count_reg == CW'(CAPACITY);
    assign drop     = (cmd_reg == CMD_DELETE) ? (rd_data_reg.tag == handle_reg)
                                              : (rd_data_reg.kind == q_reg.kind);
    assign hit      = is_query && pend_reg && (rd_data_reg.kind == q_reg.kind) && overlap;

    assign st.accepted   = accept;
    assign st.in_cmd     = cmd_t'(req.cmd);
    assign st.sweep_done = hit || (!pend_reg && !more);
    assign st.out_free   = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.found_tag = out_tag_reg;
    assign rsp.occupancy = out_occ_reg;

    always_comb
    begin
        q_next          = q_reg;
        handle_next     = handle_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        next_tag_next   = next_tag_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_next       = 1'b0;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        we              = 1'b0;
        wa              = count_reg[AW-1:0];
        wd              = q_reg;
        wd.tag          = next_tag_reg;

        if (accept)
        begin
            q_next.x        = req.pos_x;
            q_next.y        = req.pos_y;
            q_next.w        = req.width;
            q_next.h        = req.height;
            q_next.kind     = req.kind;
            q_next.tag      = '0;
            handle_next     = req.handle;
            cmd_next        = cmd_t'(req.cmd);
            res_status_next = (cmd_t'(req.cmd) == CMD_QUERY) ? ST_MISS : ST_DONE;
            res_tag_next    = '0;
            rd_idx_next     = '0;
            wr_idx_next     = '0;
        end

        if (ctl.do_exec)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        we            = 1'b1;
                        res_tag_next  = next_tag_reg;
                        next_tag_next = next_tag_reg + TAG_W'(1);
                        count_next    = count_reg + CW'(1);
                    end
                end
                CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.sweep_step)
        begin
            if (more && !hit)
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
                pend_next   = 1'b1;
            end
            if (pend_reg)
            begin
                if (is_query)
                begin
                    if (hit)
                    begin
                        res_status_next = ST_HIT;
                        res_tag_next    = rd_data_reg.tag;
                    end
                end
                else if (!drop)
                begin
                    we          = 1'b1;
                    wa          = wr_idx_reg[AW-1:0];
                    wd          = rd_data_reg;
                    wr_idx_next = wr_idx_reg + CW'(1);
                end
            end
            else if (!more && !is_query)
            begin
                count_next = wr_idx_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_occ_next    = out_occ_reg;
        if (ctl.load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_tag_next    = res_tag_reg;
            out_occ_next    = OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[wa] <= wd;
        end
        rd_data_reg <= slot_mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        handle_reg   <= handle_next;
        res_tag_reg  <= res_tag_next;
        out_status_reg <= out_status_next;
        out_tag_reg  <= out_tag_next;
        out_occ_reg  <= out_occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_INSERT;
            count_reg      <= '0;
            next_tag_reg   <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            res_status_reg <= ST_DONE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmd_reg        <= cmd_next;
            count_reg      <= count_next;
            next_tag_reg   <= next_tag_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            pend_reg       <= pend_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_pack_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.sweep_step && we) |-> (wr_idx_reg < rd_idx_reg))
        else $error("compaction write overtakes read");

    a_full_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.do_exec && cmd_reg == CMD_INSERT && full) |=> $stable(next_tag_reg))
        else $error("tag advanced on rejected insert");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.sweep_step && hit) |=> (res_status_reg == ST_HIT))
        else $error("query hit not recorded");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load_out && out_valid_reg) |-> rsp.ready)
        else $error("result overwritten before taken");
`endif

endmodule

`default_nettype wire

// ===== sim/aabb_class_collision_table_tb.sv =====
module aabb_class_collision_table_tb;
    import aabb_pkg::*;

    localparam int SLOTS = 64;
    localparam int FRAC = 4;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_WORDS = 450;

    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]        cmd;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [SIZE_W-1:0]       w;
        logic [SIZE_W-1:0]       h;
        logic [KIND_W-1:0]       kind;
        logic [TAG_W-1:0]        handle;
    } req_word_t;

    typedef struct {
        rsp_status_t      status;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occ;
    } rsp_word_t;

    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t given;
    } dir_row_t;

    logic clk;
    logic rst_n;

    aabb_req_if req();
    aabb_rsp_if rsp();

    aabb_class_collision_table #(
        .CAPACITY  (SLOTS),
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    entry_t           rects [SLOTS];
    int unsigned      live_count;
    logic [TAG_W-1:0] issue_tag;

    rsp_word_t pending_results [$];
    dir_row_t  directed_rows [$];

    int  errors;
    int  cycle_cnt;
    bit  send_idle;
    bit  recv_idle;
    bit  hold_req;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic bit overlaps(req_word_t q, entry_t e);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        ax = q.x;
        ay = q.y;
        aw = longint'(q.w) << FRAC;
        ah = longint'(q.h) << FRAC;
        bx = e.x;
        by = e.y;
        bw = longint'(e.w) << FRAC;
        bh = longint'(e.h) << FRAC;
        return ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah;
    endfunction

    function automatic void drop_where(bit by_tag, logic [TAG_W-1:0] key);
        int unsigned i, k;
        bit gone;
        k = 0;
        for (i = 0; i < live_count; i++)
        begin
            gone = by_tag ? (rects[i].tag == key) : (rects[i].kind == key[KIND_W-1:0]);
            if (!gone)
            begin
                rects[k] = rects[i];
                k++;
            end
        end
        live_count = k;
    endfunction

    function automatic rsp_word_t apply_command(req_word_t q);
        rsp_word_t r;
        int unsigned i;
        bit hit;
        r.status = ST_DONE;
        r.tag = '0;
        hit = 1'b0;
        case (q.cmd)
            CMD_INSERT:
            begin
                if (live_count >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    rects[live_count].x = q.x;
                    rects[live_count].y = q.y;
                    rects[live_count].w = q.w;
                    rects[live_count].h = q.h;
                    rects[live_count].kind = q.kind;
                    rects[live_count].tag = issue_tag;
                    r.tag = issue_tag;
                    issue_tag++;
                    live_count++;
                end
            end
            CMD_DELETE:   drop_where(1'b1, q.handle);
            CMD_DEL_KIND: drop_where(1'b0, TAG_W'(q.kind));
            CMD_CLEAR:    live_count = 0;
            CMD_QUERY:
            begin
                r.status = ST_MISS;
                for (i = 0; i < live_count; i++)
                begin
                    if (!hit && rects[i].kind == q.kind && overlaps(q, rects[i]))
                    begin
                        hit = 1'b1;
                        r.status = ST_HIT;
                        r.tag = rects[i].tag;
                    end
                end
            end
            default: ;
        endcase
        r.occ = OCC_W'(live_count);
        return r;
    endfunction

    function automatic req_word_t mk(logic [CMD_W-1:0] c, int x, int y, int w, int h,
                                     int k, int hd);
        req_word_t q;
        q.cmd = c;
        q.x = POS_W'(x);
        q.y = POS_W'(y);
        q.w = SIZE_W'(w);
        q.h = SIZE_W'(h);
        q.kind = KIND_W'(k);
        q.handle = TAG_W'(hd);
        return q;
    endfunction

    function automatic rsp_word_t want(rsp_status_t s, int t, int o);
        rsp_word_t r;
        r.status = s;
        r.tag = TAG_W'(t);
        r.occ = OCC_W'(o);
        return r;
    endfunction

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_word_t random_word();
        req_word_t q;
        entry_t e;
        int r;
        bit wide;
        r = $urandom_range(0, 99);
        wide = ($urandom_range(0, 99) < 15);
        q.x = wide ? POS_W'($urandom()) : POS_W'(near(2048));
        q.y = wide ? POS_W'($urandom()) : POS_W'(near(2048));
        q.w = SIZE_W'(wide ? $urandom() : $urandom_range(0, 48));
        q.h = SIZE_W'(wide ? $urandom() : $urandom_range(0, 48));
        q.kind = KIND_W'($urandom_range(0, 7));
        q.handle = TAG_W'($urandom());
        if (r < 40)
            q.cmd = CMD_INSERT;
        else if (r < 65)
        begin
            q.cmd = CMD_QUERY;
            if (live_count > 0 && $urandom_range(0, 99) < 75)
            begin
                e = rects[$urandom_range(0, live_count - 1)];
                q.x = POS_W'(e.x + near(400));
                q.y = POS_W'(e.y + near(400));
                if ($urandom_range(0, 99) < 80)
                    q.kind = e.kind;
            end
        end
        else if (r < 77)
        begin
            q.cmd = CMD_DELETE;
            if (live_count > 0 && $urandom_range(0, 99) < 75)
                q.handle = rects[$urandom_range(0, live_count - 1)].tag;
        end
        else if (r < 87)
            q.cmd = CMD_DEL_KIND;
        else if (r < 91)
            q.cmd = CMD_CLEAR;
        else if (r < 95)
        begin
            case ($urandom_range(0, 2))
                0:       q.cmd = CMD_RSVD_A;
                1:       q.cmd = CMD_RSVD_B;
                default: q.cmd = CMD_RSVD_C;
            endcase
        end
        else
            q.cmd = CMD_INSERT;
        return q;
    endfunction

    function automatic req_word_t local_insert(int k);
        return mk(CMD_INSERT, near(2048), near(2048), $urandom_range(0, 48),
                  $urandom_range(0, 48), k, 0);
    endfunction

    task automatic put_word(input req_word_t q, input bit typed, input rsp_word_t given);
        int g;
        rsp_word_t p;
        g = send_idle ? gap_len() : 0;
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid  <= 1'b1;
        req.cmd    <= q.cmd;
        req.pos_x  <= q.x;
        req.pos_y  <= q.y;
        req.width  <= q.w;
        req.height <= q.h;
        req.kind   <= q.kind;
        req.handle <= q.handle;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        p = apply_command(q);
        if (typed)
            p = given;
        pending_results = {pending_results, p};
    endtask

    task automatic put_checked(input req_word_t q);
        put_word(q, 1'b0, want(ST_DONE, 0, 0));
    endtask

    task automatic wait_drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic row_chk(input req_word_t q);
        dir_row_t d;
        d.word = q;
        d.typed = 1'b0;
        d.given = want(ST_DONE, 0, 0);
        directed_rows = {directed_rows, d};
    endtask

    task automatic row_exp(input req_word_t q, input rsp_status_t s, input int t, input int o);
        dir_row_t d;
        d.word = q;
        d.typed = 1'b1;
        d.given = want(s, t, o);
        directed_rows = {directed_rows, d};
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin : recv
            int hold_left;
            int stall_left;
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (recv_idle && $urandom_range(0, 99) < 25)
                    stall_left = gap_len();
            end
        end
    end

    always @(posedge clk)
    begin : check_rsp
        rsp_word_t e;
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: status %0d tag %0d occupancy %0d",
                         $time, rsp.status, rsp.found_tag, rsp.occupancy);
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp.status !== e.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d", $time, e.status, rsp.status);
                end
                if (rsp.found_tag !== e.tag)
                begin
                    errors++;
                    $display("%0t: found_tag expected %0d, got %0d", $time, e.tag,
                             rsp.found_tag);
                end
                if (rsp.occupancy !== e.occ)
                begin
                    errors++;
                    $display("%0t: occupancy expected %0d, got %0d", $time, e.occ,
                             rsp.occupancy);
                end
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        errors = 0;
        live_count = 0;
        issue_tag = '0;
        hold_req = 1'b0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        rst_n <= 1'b0;
        req.valid <= 1'b0;
        req.cmd <= CMD_INSERT;
        req.pos_x <= '0;
        req.pos_y <= '0;
        req.width <= '0;
        req.height <= '0;
        req.kind <= '0;
        req.handle <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        row_exp(mk(CMD_QUERY, 0, 0, 1, 1, 0, 0), ST_MISS, 0, 0);
        row_exp(mk(CMD_RSVD_A, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 0);
        row_exp(mk(CMD_INSERT, -524288, -524288, 4095, 4095, 0, 0), ST_DONE, 0, 1);
        row_exp(mk(CMD_INSERT, 524287, 524287, 0, 0, 7, 0), ST_DONE, 1, 2);
        row_exp(mk(CMD_INSERT, 0, 0, 10, 10, 7, 0), ST_DONE, 2, 3);
        // touching edges do not overlap
        row_chk(mk(CMD_QUERY, 160, 0, 5, 5, 7, 0));
        row_chk(mk(CMD_QUERY, 159, 159, 1, 1, 7, 0));
        row_chk(mk(CMD_QUERY, 0, 0, 0, 5, 7, 0));
        row_chk(mk(CMD_QUERY, -524288, -524288, 1, 1, 0, 0));
        row_chk(mk(CMD_QUERY, 524271, 524271, 4095, 4095, 7, 0));
        row_exp(mk(CMD_INSERT, 0, 0, 1, 1, 7, 0), ST_DONE, 3, 4);
        row_chk(mk(CMD_QUERY, 0, 0, 1, 1, 7, 0));
        row_exp(mk(CMD_RSVD_B, -1, -1, 4095, 4095, 7, 65535), ST_DONE, 0, 4);
        row_exp(mk(CMD_RSVD_C, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 4);
        row_exp(mk(CMD_DELETE, 0, 0, 0, 0, 0, 2), ST_DONE, 0, 3);
        row_chk(mk(CMD_QUERY, 0, 0, 1, 1, 7, 0));
        row_exp(mk(CMD_DELETE, 0, 0, 0, 0, 0, 65535), ST_DONE, 0, 3);
        row_exp(mk(CMD_DELETE, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 2);
        row_exp(mk(CMD_DEL_KIND, 0, 0, 0, 0, 7, 0), ST_DONE, 0, 0);
        row_exp(mk(CMD_INSERT, -16, -16, 2, 2, 3, 0), ST_DONE, 4, 1);
        row_chk(mk(CMD_QUERY, 0, 0, 1, 1, 3, 0));
        row_exp(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 0);
        row_exp(mk(CMD_QUERY, 0, 0, 1, 1, 3, 0), ST_MISS, 0, 0);
        row_exp(mk(CMD_DEL_KIND, 0, 0, 0, 0, 0, 0), ST_DONE, 0, 0);

        foreach (directed_rows[n])
            put_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].given);
        wait_drain();

        // fill past capacity
        for (i = 0; i < SLOTS + 3; i++)
            put_checked(local_insert($urandom_range(0, 7)));
        put_checked(random_word());
        wait_drain();

        // stall the result side while words keep coming
        hold_req = 1'b1;
        for (i = 0; i < 8; i++)
            put_checked(random_word());
        wait_drain();

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                hold_req = 1'b1;
            put_checked(random_word());
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
